@@ hw/rtl/tlbl_pkg.sv @@
// Package for the two-dimensional lookup table with bilinear interpolation.
// Holds the item types, opcodes, status codes, controller states and the
// command and status groups that join the controller and the datapath.
package tlbl_pkg;

   localparam int FRAC_BITS  = 16;
   localparam int MIN_POINTS = 2;
   localparam int CFG_WIDTH  = 5;
   localparam int FIELD_W    = 16;

   localparam logic [1:0]           CSR_ROWS_IN_USE = 2'd0;
   localparam logic [1:0]           CSR_COLS_IN_USE = 2'd1;
   localparam logic [CFG_WIDTH-1:0] CFG_RESET       = 5'd2;

   typedef enum logic [1:0] {
      OP_WR_ROW = 2'd0,
      OP_WR_COL = 2'd1,
      OP_WR_MAP = 2'd2,
      OP_LOOKUP = 2'd3
   } tlbl_op_type;

   typedef enum logic [1:0] {
      RSP_DONE    = 2'd0,
      RSP_WRITE   = 2'd1,
      RSP_INVALID = 2'd2
   } tlbl_status_type;

   typedef struct packed {
      logic [1:0]                opcode;
      logic [3:0]                row_index;
      logic [3:0]                col_index;
      logic signed [FIELD_W-1:0] write_value;
      logic signed [FIELD_W-1:0] row_query;
      logic signed [FIELD_W-1:0] col_query;
   } tlbl_req_type;

   typedef struct packed {
      logic signed [FIELD_W-1:0] result_value;
      logic [1:0]                status;
   } tlbl_rsp_type;

   typedef enum logic [4:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_DISPATCH,
      ST_SCAN_ROW,
      ST_END_ROW,
      ST_PREP_ROW,
      ST_DIV_ROW,
      ST_SCAN_COL,
      ST_END_COL,
      ST_PREP_COL,
      ST_DIV_COL,
      ST_RD_00,
      ST_RD_01,
      ST_RD_10,
      ST_RD_11,
      ST_RD_WAIT,
      ST_MUL_TOP,
      ST_MUL_BOT,
      ST_MUL_DIFF,
      ST_MUL_LOW,
      ST_MUL_HIGH,
      ST_FINISH,
      ST_RESPOND
   } tlbl_state_type;

   typedef enum logic [2:0] {
      STEP_NONE,
      STEP_TOP,
      STEP_BOT,
      STEP_DIFF,
      STEP_LOW,
      STEP_HIGH,
      STEP_FINISH
   } tlbl_step_type;

   typedef struct packed {
      logic            accept;
      logic            do_write;
      logic            clear;
      logic            scan;
      logic            axis;
      logic            prep;
      logic            frac_load;
      logic            map_rd;
      logic [1:0]      corner;
      tlbl_step_type   step;
      logic            rsp_load;
      tlbl_status_type status;
   } tlbl_cmd_type;

   typedef struct packed {
      tlbl_op_type op;
      logic        sizes_ok;
      logic        scan_last;
      logic        axis_ok;
      logic        div_busy;
      logic        rsp_free;
   } tlbl_stat_type;

endpackage

@@ hw/rtl/tlbl_frac_div.sv @@
// Bit-serial divider that turns an axis offset and span into a Q0.16 fraction
// rounded to nearest, one quotient bit per cycle.
// Depends on tlbl_pkg for the fraction width.
module tlbl_frac_div import tlbl_pkg::*; #(
   parameter int SPAN_W = 17
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 start,
   input  logic [SPAN_W-1:0]    span,
   input  logic [SPAN_W-1:0]    off,
   output logic                 busy,
   output logic [FRAC_BITS-1:0] frac
);

   localparam int CW = $clog2(FRAC_BITS + 1);

   logic [CW-1:0]        cnt_ff, cnt_in;
   logic [SPAN_W-1:0]    rem_ff, rem_in;
   logic [SPAN_W-1:0]    span_ff, span_in;
   logic [FRAC_BITS-1:0] quo_ff, quo_in;
   logic [SPAN_W:0]      shifted;
   logic [SPAN_W:0]      round_sum;
   logic                 take;

   assign shifted = {rem_ff, 1'b0};
   assign take    = shifted >= {1'b0, span_ff};

   always_comb begin
      cnt_in  = cnt_ff;
      rem_in  = rem_ff;
      span_in = span_ff;
      quo_in  = quo_ff;
      if (start) begin
         cnt_in  = CW'(FRAC_BITS);
         rem_in  = off;
         span_in = span;
         quo_in  = '0;
      end else if (busy) begin
         cnt_in = cnt_ff - 1'b1;
         quo_in = {quo_ff[FRAC_BITS-2:0], take};
         if (take) begin
            rem_in = SPAN_W'(shifted - {1'b0, span_ff});
         end else begin
            rem_in = shifted[SPAN_W-1:0];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff <= '0;
      end else begin
         cnt_ff <= cnt_in;
      end
      rem_ff  <= rem_in;
      span_ff <= span_in;
      quo_ff  <= quo_in;
   end

   assign busy      = cnt_ff != '0;
   assign round_sum = {1'b0, rem_ff} + {2'b0, span_ff[SPAN_W-1:1]};
   assign frac      = quo_ff + FRAC_BITS'(round_sum >= {1'b0, span_ff});

endmodule

@@ hw/rtl/tlbl_ctrl.sv @@
// Controller state machine for the lookup table: sequences the clearing
// pass, writes, axis scans, fraction divisions, map reads and the blend.
// Depends on tlbl_pkg for states, commands and status.
module tlbl_ctrl import tlbl_pkg::*; #(
   parameter int MAX_POINTS = 16
) (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  req_valid,
   output logic                                  req_stall,
   input  tlbl_stat_type                         stat,
   output tlbl_cmd_type                          cmd,
   output logic [$clog2(MAX_POINTS)-1:0]         scan_addr,
   output logic [$clog2(MAX_POINTS*MAX_POINTS)-1:0] clear_addr
);

   localparam int IW        = $clog2(MAX_POINTS);
   localparam int MAP_DEPTH = MAX_POINTS * MAX_POINTS;
   localparam int MAW       = $clog2(MAP_DEPTH);

   tlbl_state_type  state_ff, state_in;
   tlbl_status_type status_ff, status_in;
   logic [IW-1:0]   k_ff, k_in;
   logic [MAW-1:0]  clr_ff, clr_in;
   logic            clr_last;

   assign clr_last   = clr_ff == MAW'(MAP_DEPTH - 1);
   assign scan_addr  = k_ff;
   assign clear_addr = clr_ff;
   assign req_stall  = state_ff != ST_IDLE;

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_CLEAR: begin
            if (clr_last) state_in = ST_IDLE;
         end
         ST_IDLE: begin
            if (req_valid) state_in = ST_DISPATCH;
         end
         ST_DISPATCH: begin
            if (stat.op != OP_LOOKUP || !stat.sizes_ok) begin
               state_in = ST_RESPOND;
            end else begin
               state_in = ST_SCAN_ROW;
            end
         end
         ST_SCAN_ROW: begin
            if (stat.scan_last) state_in = ST_END_ROW;
         end
         ST_END_ROW:  state_in = ST_PREP_ROW;
         ST_PREP_ROW: state_in = stat.axis_ok ? ST_DIV_ROW : ST_RESPOND;
         ST_DIV_ROW: begin
            if (!stat.div_busy) state_in = ST_SCAN_COL;
         end
         ST_SCAN_COL: begin
            if (stat.scan_last) state_in = ST_END_COL;
         end
         ST_END_COL:  state_in = ST_PREP_COL;
         ST_PREP_COL: state_in = stat.axis_ok ? ST_DIV_COL : ST_RESPOND;
         ST_DIV_COL: begin
            if (!stat.div_busy) state_in = ST_RD_00;
         end
         ST_RD_00:    state_in = ST_RD_01;
         ST_RD_01:    state_in = ST_RD_10;
         ST_RD_10:    state_in = ST_RD_11;
         ST_RD_11:    state_in = ST_RD_WAIT;
         ST_RD_WAIT:  state_in = ST_MUL_TOP;
         ST_MUL_TOP:  state_in = ST_MUL_BOT;
         ST_MUL_BOT:  state_in = ST_MUL_DIFF;
         ST_MUL_DIFF: state_in = ST_MUL_LOW;
         ST_MUL_LOW:  state_in = ST_MUL_HIGH;
         ST_MUL_HIGH: state_in = ST_FINISH;
         ST_FINISH:   state_in = ST_RESPOND;
         ST_RESPOND: begin
            if (stat.rsp_free) state_in = ST_IDLE;
         end
         default:     state_in = ST_IDLE;
      endcase
   end

   always_comb begin
      cmd        = '0;
      cmd.step   = STEP_NONE;
      cmd.status = status_ff;
      unique case (state_ff)
         ST_CLEAR:    cmd.clear = 1'b1;
         ST_IDLE:     cmd.accept = req_valid;
         ST_DISPATCH: cmd.do_write = stat.op != OP_LOOKUP;
         ST_SCAN_ROW: cmd.scan = 1'b1;
         ST_END_ROW:  cmd.axis = 1'b0;
         ST_PREP_ROW: cmd.prep = 1'b1;
         ST_DIV_ROW:  cmd.frac_load = !stat.div_busy;
         ST_SCAN_COL: begin
            cmd.scan = 1'b1;
            cmd.axis = 1'b1;
         end
         ST_END_COL:  cmd.axis = 1'b1;
         ST_PREP_COL: begin
            cmd.prep = 1'b1;
            cmd.axis = 1'b1;
         end
         ST_DIV_COL: begin
            cmd.frac_load = !stat.div_busy;
            cmd.axis      = 1'b1;
         end
         ST_RD_00: begin
            cmd.map_rd = 1'b1;
            cmd.corner = 2'b00;
         end
         ST_RD_01: begin
            cmd.map_rd = 1'b1;
            cmd.corner = 2'b01;
         end
         ST_RD_10: begin
            cmd.map_rd = 1'b1;
            cmd.corner = 2'b10;
         end
         ST_RD_11: begin
            cmd.map_rd = 1'b1;
            cmd.corner = 2'b11;
         end
         ST_RD_WAIT:  cmd.step = STEP_NONE;
         ST_MUL_TOP:  cmd.step = STEP_TOP;
         ST_MUL_BOT:  cmd.step = STEP_BOT;
         ST_MUL_DIFF: cmd.step = STEP_DIFF;
         ST_MUL_LOW:  cmd.step = STEP_LOW;
         ST_MUL_HIGH: cmd.step = STEP_HIGH;
         ST_FINISH:   cmd.step = STEP_FINISH;
         ST_RESPOND:  cmd.rsp_load = stat.rsp_free;
         default:     cmd.step = STEP_NONE;
      endcase
   end

   always_comb begin
      status_in = status_ff;
      if (state_ff == ST_DISPATCH) begin
         if (stat.op != OP_LOOKUP) begin
            status_in = RSP_WRITE;
         end else if (!stat.sizes_ok) begin
            status_in = RSP_INVALID;
         end else begin
            status_in = RSP_DONE;
         end
      end else if ((state_ff == ST_PREP_ROW || state_ff == ST_PREP_COL) && !stat.axis_ok) begin
         status_in = RSP_INVALID;
      end
      if ((state_ff == ST_SCAN_ROW || state_ff == ST_SCAN_COL) && !stat.scan_last) begin
         k_in = k_ff + 1'b1;
      end else begin
         k_in = '0;
      end
      clr_in = (state_ff == ST_CLEAR) ? clr_ff + 1'b1 : '0;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= ST_CLEAR;
         status_ff <= RSP_DONE;
         k_ff      <= '0;
         clr_ff    <= '0;
      end else begin
         state_ff  <= state_in;
         status_ff <= status_in;
         k_ff      <= k_in;
         clr_ff    <= clr_in;
      end
   end

endmodule

@@ hw/rtl/tlbl_datapath.sv @@
// Datapath of the lookup table: configuration registers, breakpoint and map
// memories, axis scan, fraction divider, blend multiplier and result register.
// Depends on tlbl_pkg and tlbl_frac_div.
module tlbl_datapath import tlbl_pkg::*; #(
   parameter int MAX_POINTS = 16,
   parameter int DATA_WIDTH = 16
) (
   input  logic                                     clock,
   input  logic                                     reset,
   input  tlbl_req_type                             req_data,
   output tlbl_rsp_type                             rsp_data,
   output logic                                     rsp_valid,
   input  logic                                     rsp_stall,
   input  logic                                     csr_valid,
   input  logic [1:0]                               csr_index,
   input  logic [CFG_WIDTH-1:0]                     csr_data,
   input  tlbl_cmd_type                             cmd,
   output tlbl_stat_type                            stat,
   input  logic [$clog2(MAX_POINTS)-1:0]            scan_addr,
   input  logic [$clog2(MAX_POINTS*MAX_POINTS)-1:0] clear_addr
);

   localparam int DW        = DATA_WIDTH;
   localparam int IW        = $clog2(MAX_POINTS);
   localparam int MAP_DEPTH = MAX_POINTS * MAX_POINTS;
   localparam int MAW       = $clog2(MAP_DEPTH);
   localparam int CNTW      = $clog2(MAX_POINTS + 1);
   localparam int CW        = (DW > FIELD_W) ? DW : FIELD_W;
   localparam int SW        = DW + 1;
   localparam int MW        = (DW + 2 > FRAC_BITS + 1) ? DW + 2 : FRAC_BITS + 1;
   localparam int PW        = MW + FRAC_BITS + 1;
   localparam int TW        = DW + FRAC_BITS + 1;
   localparam int DTW       = TW + 1;
   localparam int AW        = DW + 2 * FRAC_BITS + 2;

   tlbl_req_type          req_ff;
   logic [CFG_WIDTH-1:0]  rows_ff, cols_ff;
   logic signed [DW-1:0]  row_bp [MAX_POINTS];
   logic signed [DW-1:0]  col_bp [MAX_POINTS];
   logic signed [DW-1:0]  map_mem [MAP_DEPTH];
   logic signed [DW-1:0]  row_rd_ff, col_rd_ff, map_rd_ff;

   logic signed [DW-1:0]  wr_value;
   logic                  row_we, col_we, map_we;
   logic [IW-1:0]         row_waddr, col_waddr;
   logic [MAW-1:0]        map_waddr, map_raddr;

   logic                  pend_ff, first_ff;
   logic [CNTW-1:0]       cnt_ff;
   logic                  ok_ff, hi_got_ff;
   logic signed [DW-1:0]  prev_ff, lo_ff, hi_ff;
   logic signed [DW-1:0]  scan_d;
   logic signed [CW-1:0]  q_ext;
   logic                  le;
   logic [CFG_WIDTH-1:0]  n_axis;

   logic                  clamp_lo, clamp_hi, clamp_ff;
   logic [IW-1:0]         idx_lo, idx_hi;
   logic [IW-1:0]         r0_ff, r1_ff, c0_ff, c1_ff;
   logic [SW-1:0]         span, off;
   logic signed [CW:0]    off_wide;
   logic                  div_busy;
   logic [FRAC_BITS-1:0]  div_frac;
   logic [FRAC_BITS-1:0]  fr_ff, fc_ff;

   logic                  mrd_pend_ff;
   logic [1:0]            corner_ff;
   logic signed [DW-1:0]  a_ff [4];
   logic signed [MW-1:0]  mul_a;
   logic [FRAC_BITS-1:0]  mul_f;
   logic signed [PW-1:0]  prod;
   logic signed [PW-1:0]  p_ff, plo_ff;
   logic signed [TW-1:0]  top_ff, bot_ff;
   logic signed [DTW-1:0] diff;
   logic signed [AW-1:0]  acc, rnd;
   logic signed [DW-1:0]  last_ff;
   logic                  rsp_valid_ff;
   tlbl_rsp_type          rsp_ff;

   // Configuration and item capture.
   always_ff @(posedge clock) begin
      if (reset) begin
         rows_ff <= CFG_RESET;
         cols_ff <= CFG_RESET;
      end else if (csr_valid) begin
         if (csr_index == CSR_ROWS_IN_USE) rows_ff <= csr_data;
         if (csr_index == CSR_COLS_IN_USE) cols_ff <= csr_data;
      end
      if (cmd.accept) req_ff <= req_data;
   end

   assign wr_value  = cmd.clear ? '0 : DW'(req_ff.write_value);
   assign row_we    = cmd.clear ? (int'(clear_addr) < MAX_POINTS)
                    : (cmd.do_write && req_ff.opcode == OP_WR_ROW
                       && int'(req_ff.row_index) < MAX_POINTS);
   assign col_we    = cmd.clear ? (int'(clear_addr) < MAX_POINTS)
                    : (cmd.do_write && req_ff.opcode == OP_WR_COL
                       && int'(req_ff.col_index) < MAX_POINTS);
   assign map_we    = cmd.clear
                    || (cmd.do_write && req_ff.opcode == OP_WR_MAP
                        && int'(req_ff.row_index) < MAX_POINTS
                        && int'(req_ff.col_index) < MAX_POINTS);
   assign row_waddr = cmd.clear ? clear_addr[IW-1:0] : IW'(req_ff.row_index);
   assign col_waddr = cmd.clear ? clear_addr[IW-1:0] : IW'(req_ff.col_index);
   assign map_waddr = cmd.clear ? clear_addr
                    : MAW'(int'(req_ff.row_index) * MAX_POINTS + int'(req_ff.col_index));
   assign map_raddr = MAW'(int'(cmd.corner[1] ? r1_ff : r0_ff) * MAX_POINTS
                           + int'(cmd.corner[0] ? c1_ff : c0_ff));

   always_ff @(posedge clock) begin
      if (row_we) row_bp[row_waddr] <= wr_value;
      if (col_we) col_bp[col_waddr] <= wr_value;
      row_rd_ff <= row_bp[scan_addr];
      col_rd_ff <= col_bp[scan_addr];
   end

   always_ff @(posedge clock) begin
      if (map_we) map_mem[map_waddr] <= wr_value;
      map_rd_ff <= map_mem[map_raddr];
   end

   // Axis scan: validity and bracketing search in one pass.
   assign n_axis = cmd.axis ? cols_ff : rows_ff;
   assign scan_d = cmd.axis ? col_rd_ff : row_rd_ff;
   assign q_ext  = cmd.axis ? CW'(req_ff.col_query) : CW'(req_ff.row_query);
   assign le     = CW'(scan_d) <= q_ext;

   always_ff @(posedge clock) begin
      if (reset) begin
         pend_ff <= 1'b0;
      end else begin
         pend_ff <= cmd.scan;
      end
      first_ff <= scan_addr == '0;
      if (pend_ff) begin
         prev_ff <= scan_d;
         if (first_ff) begin
            ok_ff     <= 1'b1;
            cnt_ff    <= CNTW'(le);
            lo_ff     <= scan_d;
            hi_ff     <= scan_d;
            hi_got_ff <= !le;
         end else begin
            ok_ff <= ok_ff && (scan_d > prev_ff);
            if (le) begin
               cnt_ff <= cnt_ff + 1'b1;
               lo_ff  <= scan_d;
            end else if (!hi_got_ff) begin
               hi_ff     <= scan_d;
               hi_got_ff <= 1'b1;
            end
         end
      end
   end

   // Bracketing indices and fraction.
   assign clamp_lo = cnt_ff == '0;
   assign clamp_hi = int'(cnt_ff) >= int'(n_axis);
   always_comb begin
      if (clamp_lo) begin
         idx_lo = '0;
         idx_hi = '0;
      end else if (clamp_hi) begin
         idx_lo = IW'(int'(n_axis) - 1);
         idx_hi = IW'(int'(n_axis) - 1);
      end else begin
         idx_lo = IW'(int'(cnt_ff) - 1);
         idx_hi = IW'(cnt_ff);
      end
   end

   assign span     = SW'(SW'(hi_ff) - SW'(lo_ff));
   assign off_wide = (CW + 1)'(q_ext) - (CW + 1)'(lo_ff);
   assign off      = off_wide[SW-1:0];

   tlbl_frac_div #(
      .SPAN_W(SW)
   ) u_frac_div (
      .clock(clock),
      .reset(reset),
      .start(cmd.prep),
      .span (span),
      .off  (off),
      .busy (div_busy),
      .frac (div_frac)
   );

   always_ff @(posedge clock) begin
      if (cmd.prep) begin
         clamp_ff <= clamp_lo || clamp_hi;
         if (cmd.axis) begin
            c0_ff <= idx_lo;
            c1_ff <= idx_hi;
         end else begin
            r0_ff <= idx_lo;
            r1_ff <= idx_hi;
         end
      end
      if (cmd.frac_load) begin
         if (cmd.axis) begin
            fc_ff <= clamp_ff ? '0 : div_frac;
         end else begin
            fr_ff <= clamp_ff ? '0 : div_frac;
         end
      end
   end

   // Corner reads and blend.
   always_ff @(posedge clock) begin
      if (reset) begin
         mrd_pend_ff <= 1'b0;
      end else begin
         mrd_pend_ff <= cmd.map_rd;
      end
      corner_ff <= cmd.corner;
      if (mrd_pend_ff) a_ff[corner_ff] <= map_rd_ff;
   end

   assign diff = DTW'(bot_ff) - DTW'(top_ff);

   always_comb begin
      case (cmd.step)
         STEP_TOP: begin
            mul_a = MW'(a_ff[1]) - MW'(a_ff[0]);
            mul_f = fc_ff;
         end
         STEP_BOT: begin
            mul_a = MW'(a_ff[3]) - MW'(a_ff[2]);
            mul_f = fc_ff;
         end
         STEP_LOW: begin
            mul_a = $signed({{(MW - FRAC_BITS){1'b0}}, diff[FRAC_BITS-1:0]});
            mul_f = fr_ff;
         end
         STEP_HIGH: begin
            mul_a = MW'(diff >>> FRAC_BITS);
            mul_f = fr_ff;
         end
         default: begin
            mul_a = '0;
            mul_f = '0;
         end
      endcase
   end

   assign prod = PW'(mul_a) * PW'($signed({1'b0, mul_f}));
   assign acc  = (AW'(top_ff) <<< FRAC_BITS) + (AW'(p_ff) <<< FRAC_BITS) + AW'(plo_ff);
   assign rnd  = acc + (AW'(1) <<< (2 * FRAC_BITS - 1));

   always_ff @(posedge clock) begin
      if (reset) begin
         last_ff <= '0;
      end else if (cmd.step == STEP_FINISH) begin
         last_ff <= rnd[DW+2*FRAC_BITS-1:2*FRAC_BITS];
      end
      case (cmd.step)
         STEP_TOP: p_ff <= prod;
         STEP_BOT: begin
            top_ff <= (TW'(a_ff[0]) <<< FRAC_BITS) + TW'(p_ff);
            p_ff   <= prod;
         end
         STEP_DIFF: bot_ff <= (TW'(a_ff[2]) <<< FRAC_BITS) + TW'(p_ff);
         STEP_LOW:  p_ff <= prod;
         STEP_HIGH: begin
            plo_ff <= p_ff;
            p_ff   <= prod;
         end
         default: p_ff <= p_ff;
      endcase
   end

   // Result register.
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (cmd.rsp_load) begin
         rsp_valid_ff <= 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_ff <= 1'b0;
      end
      if (cmd.rsp_load) begin
         rsp_ff.result_value <= FIELD_W'(last_ff);
         rsp_ff.status       <= cmd.status;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

   assign stat.op        = tlbl_op_type'(req_ff.opcode);
   assign stat.sizes_ok  = int'(rows_ff) >= MIN_POINTS && int'(rows_ff) <= MAX_POINTS
                        && int'(cols_ff) >= MIN_POINTS && int'(cols_ff) <= MAX_POINTS;
   assign stat.scan_last = int'(scan_addr) == int'(n_axis) - 1;
   assign stat.axis_ok   = ok_ff;
   assign stat.div_busy  = div_busy;
   assign stat.rsp_free  = !rsp_valid_ff || !rsp_stall;

endmodule

@@ hw/rtl/table2d_bilinear_lookup_unit.sv @@
// Top level of the two-dimensional lookup table with bilinear interpolation.
// Depends on tlbl_pkg, tlbl_ctrl and tlbl_datapath.
//
//   Channel  Signals                          Direction  Moves
//   req      req_valid req_stall req_data     in         one write or lookup item
//   rsp      rsp_valid rsp_stall rsp_data     out        one result item per item
//   csr      csr_valid csr_ready csr_index    in         rows_in_use, cols_in_use
//            csr_data
//
// A write item is written in the dispatch state and answered in the respond state; a
// lookup runs longer with the N row and M column breakpoints in use, set by the
// one-entry-per-cycle axis scans, and with the bit-serial fraction divide run once
// per axis. After reset a clearing pass over every map address zeroes the
// memories, during which no item is taken. A stalled result holds in the
// output register while the next item may already be accepted.
module table2d_bilinear_lookup_unit import tlbl_pkg::*; #(
   parameter int MAX_POINTS = 16,
   parameter int DATA_WIDTH = 16
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_stall,
   input  tlbl_req_type         req_data,
   output logic                 rsp_valid,
   input  logic                 rsp_stall,
   output tlbl_rsp_type         rsp_data,
   input  logic                 csr_valid,
   output logic                 csr_ready,
   input  logic [1:0]           csr_index,
   input  logic [CFG_WIDTH-1:0] csr_data
);

   tlbl_cmd_type                            cmd;
   tlbl_stat_type                           stat;
   logic [$clog2(MAX_POINTS)-1:0]            scan_addr;
   logic [$clog2(MAX_POINTS*MAX_POINTS)-1:0] clear_addr;

   assign csr_ready = 1'b1;

   tlbl_ctrl #(
      .MAX_POINTS(MAX_POINTS)
   ) u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .stat      (stat),
      .cmd       (cmd),
      .scan_addr (scan_addr),
      .clear_addr(clear_addr)
   );

   tlbl_datapath #(
      .MAX_POINTS(MAX_POINTS),
      .DATA_WIDTH(DATA_WIDTH)
   ) u_datapath (
      .clock     (clock),
      .reset     (reset),
      .req_data  (req_data),
      .rsp_data  (rsp_data),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .csr_valid (csr_valid && csr_ready),
      .csr_index (csr_index),
      .csr_data  (csr_data),
      .cmd       (cmd),
      .stat      (stat),
      .scan_addr (scan_addr),
      .clear_addr(clear_addr)
   );

endmodule

@@ tb/sv/tb_top.sv @@
// Testbench for table2d_bilinear_lookup_unit: loads axes and map cells, runs
// lookups and checks each result against a predictor kept in this file.
// Depends on tlbl_pkg and the RTL of the lookup unit.
module tb_top;
   import tlbl_pkg::*;

   localparam int WATCHDOG_LIMIT = 20000;
   localparam int SETTLE_CYCLES  = 150;
   localparam logic [1:0] CSR_SPARE_LO = 2'd2;
   localparam logic [1:0] CSR_SPARE_HI = 2'd3;

   typedef logic signed [FIELD_W-1:0] axis_type [16];

   logic         clock = 1'b0;
   logic         reset = 1'b1;
   logic         req_valid = 1'b0;
   logic         req_stall;
   tlbl_req_type req_data = '0;
   logic         rsp_valid;
   logic         rsp_stall = 1'b0;
   tlbl_rsp_type rsp_data;
   logic         csr_valid = 1'b0;
   logic         csr_ready;
   logic [1:0]   csr_index = '0;
   logic [CFG_WIDTH-1:0] csr_data = '0;

   axis_type                  row_bps, col_bps;
   logic signed [FIELD_W-1:0] grid [16][16];
   logic signed [FIELD_W-1:0] held_value;
   logic [CFG_WIDTH-1:0]      row_count, col_count;

   tlbl_rsp_type expected_results[$];
   int mismatches = 0;
   int idle_cycles = 0;
   int send_idle_pct = 0;
   int stall_pct = 0;

   table2d_bilinear_lookup_unit dut (.*);

   always begin
      #6 clock = 1'b1;
      #6 clock = 1'b0;
   end

   function automatic bit axis_valid(axis_type a, int n);
      if (n < MIN_POINTS || n > 16) return 0;
      for (int k = 1; k < n; k++)
         if (a[k] <= a[k-1]) return 0;
      return 1;
   endfunction

   function automatic void find_cell(axis_type a, int n, longint q,
                                     output int lo, output int hi, output longint frac);
      int i;
      longint span;
      i = 0;
      for (int k = 0; k < n; k++)
         if (longint'(a[k]) <= q) i = k + 1;
      if (i == 0) begin
         lo = 0; hi = 0; frac = 0;
      end else if (i >= n) begin
         lo = n - 1; hi = n - 1; frac = 0;
      end else begin
         span = longint'(a[i]) - longint'(a[i-1]);
         lo = i - 1; hi = i;
         frac = ((q - longint'(a[i-1])) * 65536 + span / 2) / span;
      end
   endfunction

   function automatic tlbl_rsp_type table_step(tlbl_req_type item);
      tlbl_rsp_type r;
      int r0, r1, c0, c1;
      longint fr, fc, top, bot, acc;
      case (tlbl_op_type'(item.opcode))
         OP_LOOKUP: begin
            if (axis_valid(row_bps, int'(row_count)) &&
                axis_valid(col_bps, int'(col_count))) begin
               find_cell(row_bps, int'(row_count), longint'(item.row_query), r0, r1, fr);
               find_cell(col_bps, int'(col_count), longint'(item.col_query), c0, c1, fc);
               top = longint'(grid[r0][c0]) * (65536 - fc) + longint'(grid[r0][c1]) * fc;
               bot = longint'(grid[r1][c0]) * (65536 - fc) + longint'(grid[r1][c1]) * fc;
               acc = top * (65536 - fr) + bot * fr;
               acc = (acc + (longint'(1) <<< 31)) >>> 32;
               held_value = acc[FIELD_W-1:0];
               r.status = RSP_DONE;
            end else begin
               r.status = RSP_INVALID;
            end
         end
         OP_WR_ROW: begin
            row_bps[item.row_index] = item.write_value;
            r.status = RSP_WRITE;
         end
         OP_WR_COL: begin
            col_bps[item.col_index] = item.write_value;
            r.status = RSP_WRITE;
         end
         default: begin
            grid[item.row_index][item.col_index] = item.write_value;
            r.status = RSP_WRITE;
         end
      endcase
      r.result_value = held_value;
      return r;
   endfunction

   task automatic send_item(tlbl_req_type item);
      while ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(negedge clock);
      end
      req_valid <= 1'b1;
      req_data  <= item;
      do @(posedge clock); while (req_stall);
      expected_results.push_back(table_step(item));
      @(negedge clock);
   endtask

   task automatic write_csr(logic [1:0] index, logic [CFG_WIDTH-1:0] value);
      req_valid <= 1'b0;
      wait (expected_results.size() == 0);
      repeat (SETTLE_CYCLES) @(posedge clock);
      @(negedge clock);
      csr_valid <= 1'b1;
      csr_index <= index;
      csr_data  <= value;
      do @(posedge clock); while (!csr_ready);
      if (index == CSR_ROWS_IN_USE) row_count = value;
      else if (index == CSR_COLS_IN_USE) col_count = value;
      @(negedge clock);
      csr_valid <= 1'b0;
   endtask

   task automatic send_write(tlbl_op_type op, int ri, int ci, int value);
      tlbl_req_type item;
      item = '0;
      item.opcode = op;
      item.row_index = 4'(ri);
      item.col_index = 4'(ci);
      item.write_value = FIELD_W'(value);
      item.row_query = FIELD_W'($urandom);
      item.col_query = FIELD_W'($urandom);
      send_item(item);
   endtask

   task automatic send_lookup(int rq, int cq);
      tlbl_req_type item;
      item = '0;
      item.opcode = OP_LOOKUP;
      item.row_index = 4'($urandom);
      item.col_index = 4'($urandom);
      item.write_value = FIELD_W'($urandom);
      item.row_query = FIELD_W'(rq);
      item.col_query = FIELD_W'(cq);
      send_item(item);
   endtask

   task automatic test_directed();
      send_lookup(0, 0);
      send_write(OP_WR_ROW, 0, 3, -32768);
      send_write(OP_WR_ROW, 1, 5, 32767);
      send_write(OP_WR_COL, 9, 0, -32768);
      send_write(OP_WR_COL, 2, 1, 32767);
      send_write(OP_WR_MAP, 0, 0, 32767);
      send_write(OP_WR_MAP, 0, 1, -32768);
      send_write(OP_WR_MAP, 1, 0, -32768);
      send_write(OP_WR_MAP, 1, 1, 32767);
      send_write(OP_WR_MAP, 15, 15, 1234);
      send_lookup(-32768, -32768);
      send_lookup(32767, 32767);
      send_lookup(32767, -32768);
      send_lookup(0, 0);
      send_lookup(-1, 16383);
      send_write(OP_WR_ROW, 1, 0, -32768);
      send_lookup(100, 100);
      send_write(OP_WR_ROW, 1, 0, 100);
      send_lookup(100, -32768);
      send_lookup(99, 32767);
      write_csr(CSR_ROWS_IN_USE, 5'd31);
      send_lookup(0, 0);
      write_csr(CSR_SPARE_LO, 5'd7);
      write_csr(CSR_SPARE_HI, 5'd1);
      write_csr(CSR_ROWS_IN_USE, 5'd2);
      send_lookup(50, 0);
   endtask

   task automatic load_axis(tlbl_op_type op, int n, ref int points[16]);
      int v;
      v = $urandom_range(0, 1000) - 32768;
      for (int k = 0; k < 16; k++) begin
         points[k] = v;
         if (k < n) send_write(op, k, k, v);
         v += ($urandom_range(3) == 0) ? 1 : $urandom_range(1, 4000);
      end
   endtask

   function automatic int pick_query(ref int points[16], int n);
      int q;
      case ($urandom_range(5))
         0: q = $urandom_range(0, 65535) - 32768;
         1: q = points[$urandom_range(0, n - 1)];
         default: q = $urandom_range(0, points[n-1] - points[0] + 400) + points[0] - 200;
      endcase
      if (q > 32767) q = 32767;
      if (q < -32768) q = -32768;
      return q;
   endfunction

   task automatic test_random(int count);
      int rows, cols, sent;
      int row_pts[16], col_pts[16];
      sent = 0;
      while (sent < count) begin
         case ($urandom_range(9))
            0: rows = 16;
            1: rows = 2;
            2: rows = $urandom_range(0, 31);
            default: rows = $urandom_range(2, 6);
         endcase
         cols = ($urandom_range(4) == 0) ? $urandom_range(0, 31) : $urandom_range(2, 6);
         write_csr(CSR_ROWS_IN_USE, CFG_WIDTH'(rows));
         write_csr(CSR_COLS_IN_USE, CFG_WIDTH'(cols));
         rows = (rows < 2) ? 2 : (rows > 16 ? 16 : rows);
         cols = (cols < 2) ? 2 : (cols > 16 ? 16 : cols);
         load_axis(OP_WR_ROW, rows, row_pts);
         load_axis(OP_WR_COL, cols, col_pts);
         sent += rows + cols;
         for (int k = 0; k < 60; k++) begin
            case ($urandom_range(19))
               0, 1, 2, 3, 4:
                  send_write(OP_WR_MAP, $urandom_range(0, rows - 1),
                             $urandom_range(0, cols - 1), $urandom_range(0, 65535));
               5: send_write(OP_WR_MAP, $urandom, $urandom, $urandom);
               6: send_write(tlbl_op_type'($urandom_range(0, 1)), $urandom, $urandom,
                             $urandom);
               default: send_lookup(pick_query(row_pts, rows), pick_query(col_pts, cols));
            endcase
            sent++;
         end
      end
   endtask

   always @(negedge clock)
      rsp_stall <= ($urandom_range(99) < stall_pct);

   always @(posedge clock) begin
      if (!reset && rsp_valid && !rsp_stall) begin
         if (expected_results.size() == 0) begin
            mismatches++;
            if (mismatches <= 10)
               $display("unexpected result: value %0d status %0d",
                        rsp_data.result_value, rsp_data.status);
         end else begin
            tlbl_rsp_type want;
            want = expected_results.pop_front();
            if (want.result_value !== rsp_data.result_value ||
                want.status !== rsp_data.status) begin
               mismatches++;
               if (mismatches <= 10)
                  $display("mismatch: expected value %0d status %0d, got value %0d status %0d",
                           want.result_value, want.status,
                           rsp_data.result_value, rsp_data.status);
            end
         end
      end
   end

   always @(posedge clock) begin
      if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall) || (csr_valid && csr_ready))
         idle_cycles <= 0;
      else
         idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= WATCHDOG_LIMIT) begin
         $display("tb_top failed");
         $finish;
      end
   end

   initial begin
      for (int i = 0; i < 16; i++) begin
         row_bps[i] = '0;
         col_bps[i] = '0;
         for (int j = 0; j < 16; j++) grid[i][j] = '0;
      end
      held_value = '0;
      row_count = CFG_RESET;
      col_count = CFG_RESET;
      repeat (2) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      test_directed();
      send_idle_pct = 0;  stall_pct = 0;  test_random(500);
      send_idle_pct = 51; stall_pct = 0;  test_random(500);
      send_idle_pct = 0;  stall_pct = 51; test_random(500);
      send_idle_pct = 20; stall_pct = 20; test_random(500);
      write_csr(CSR_ROWS_IN_USE, 5'd16);
      write_csr(CSR_COLS_IN_USE, 5'd16);
      send_lookup(0, 0);
      req_valid <= 1'b0;
      wait (expected_results.size() == 0);
      repeat (SETTLE_CYCLES) @(posedge clock);
      if (mismatches == 0 && expected_results.size() == 0)
         $display("tb_top passed");
      else
         $display("tb_top failed");
      $finish;
   end
endmodule
